// File: sv/btm_request_frame_parser_assert.svh
// Assertion macros for the checker file of the frame parser.
// Both sample on clk and are switched off while rst_n is low.
`ifndef BTM_REQUEST_FRAME_PARSER_ASSERT_SVH
`define BTM_REQUEST_FRAME_PARSER_ASSERT_SVH

// Same-cycle implication.
`define BTM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BTM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/btm_rfp_pkg.sv
// ----------------------------------------------------------------------------
// btm_rfp_pkg
// Types, codes and constants of the BTM request frame parser.
// ----------------------------------------------------------------------------
package btm_rfp_pkg;

  localparam int unsigned MAX_CANDIDATES_DEF = 8;
  localparam int unsigned QUEUE_DEPTH        = 4;

  // Header offsets
  localparam logic [4:0] OFF_CTRL     = 5'd0;
  localparam logic [4:0] OFF_A1_FIRST = 5'd4;
  localparam logic [4:0] OFF_A1_LAST  = 5'd9;
  localparam logic [4:0] OFF_A3_FIRST = 5'd16;
  localparam logic [4:0] OFF_A3_LAST  = 5'd21;
  localparam logic [4:0] OFF_CATEGORY = 5'd24;
  localparam logic [4:0] OFF_ACTION   = 5'd25;
  localparam logic [4:0] OFF_SAT      = 5'd26;

  localparam logic [7:0] FC_ACTION    = 8'hD0;
  localparam logic [7:0] CAT_WNM      = 8'd10;
  localparam logic [7:0] ACT_BTM_REQ  = 8'd7;
  localparam logic [7:0] TAG_NEIGHBOR = 8'd52;
  localparam logic [7:0] MIN_NR_LEN   = 8'd13;
  localparam logic [7:0] TERM_LEN     = 8'd12;
  localparam logic [8:0] FIXED_LAST   = 9'd4;   // five fixed bytes, index 0..4
  localparam logic [8:0] BSSID_BYTES  = 9'd6;

  localparam int unsigned MODE_TERM_BIT = 3;
  localparam int unsigned MODE_URL_BIT  = 4;

  // Result kinds
  localparam logic [2:0] KIND_CAND       = 3'd0;
  localparam logic [2:0] KIND_NOT_ACTION = 3'd1;
  localparam logic [2:0] KIND_OTHER      = 3'd2;
  localparam logic [2:0] KIND_TRUNC      = 3'd3;
  localparam logic [2:0] KIND_BTM        = 3'd4;

  typedef enum logic [2:0] {
    PH_HDR    = 3'd0,
    PH_OTHER  = 3'd1,
    PH_FIXED  = 3'd2,
    PH_TERM   = 3'd3,
    PH_URLLEN = 3'd4,
    PH_URL    = 3'd5,
    PH_ELEM   = 3'd6
  } phase_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [7:0]  category;
    logic [7:0]  action_code;
    logic [7:0]  token_byte;
    logic [7:0]  mode_bits;
    logic [15:0] disassoc_delay;
    logic [7:0]  validity_window;
    logic [47:0] target_station;
    logic [47:0] bss_address;
    logic [3:0]  candidate_number;
    logic        candidates_dropped;
    logic        end_of_frame;
  } out_word_t;

  // One queue entry: what a single byte produced (a candidate, a summary or both)
  typedef struct packed {
    logic        cand;
    logic        summ;
    logic [2:0]  skind;
    logic [7:0]  category;
    logic [7:0]  action;
    logic [39:0] fixed;
    logic [47:0] station;
    logic [47:0] cand_addr;
    logic [47:0] bssid;
    logic [3:0]  cnum;
    logic        dropped;
  } evt_t;

  function automatic phase_t after_term(input logic [7:0] mode);
    return mode[MODE_URL_BIT] ? PH_URLLEN : PH_ELEM;
  endfunction

endpackage

// File: sv/btm_rfp_front.sv
// ----------------------------------------------------------------------------
// btm_rfp_front
// Byte parser: tracks the frame phase and emits one event per byte that
// completes a candidate or ends the frame.
// ----------------------------------------------------------------------------
module btm_rfp_front #(
  parameter int unsigned MAX_CANDIDATES = btm_rfp_pkg::MAX_CANDIDATES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  btm_rfp_pkg::in_word_t in_word,
  output logic                  evt_push,
  output btm_rfp_pkg::evt_t     evt
);
  import btm_rfp_pkg::*;

  localparam int unsigned CW = $clog2(MAX_CANDIDATES + 1);

  logic [4:0]    offset_r,  offset_nxt;
  phase_t        phase_r,   phase_nxt;
  logic [7:0]    ctrl_r,    ctrl_nxt;
  logic [7:0]    cat_r,     cat_nxt;
  logic [7:0]    act_r,     act_nxt;
  logic [39:0]   fixed_r,   fixed_nxt;
  logic [47:0]   station_r, station_nxt;
  logic [47:0]   bssid_r,   bssid_nxt;
  logic [7:0]    skip_r,    skip_nxt;
  logic [7:0]    tag_r,     tag_nxt;
  logic [7:0]    len_r,     len_nxt;
  logic [8:0]    pos_r,     pos_nxt;   // up to 256 inside a 255-byte element
  logic [47:0]   cshift_r,  cshift_nxt;
  logic [CW-1:0] ctotal_r,  ctotal_nxt;
  logic          ovf_r,     ovf_nxt;

  logic [7:0] b;
  logic [8:0] body;
  logic       done;
  logic       cand_hit;

  assign b = in_word.frame_byte;

  // Next state
  always_comb begin
    offset_nxt  = (offset_r < OFF_SAT) ? offset_r + 5'd1 : offset_r;
    phase_nxt   = phase_r;
    ctrl_nxt    = ctrl_r;
    cat_nxt     = cat_r;
    act_nxt     = act_r;
    fixed_nxt   = fixed_r;
    station_nxt = station_r;
    bssid_nxt   = bssid_r;
    skip_nxt    = skip_r;
    tag_nxt     = tag_r;
    len_nxt     = len_r;
    pos_nxt     = pos_r;
    cshift_nxt  = cshift_r;
    ctotal_nxt  = ctotal_r;
    ovf_nxt     = ovf_r;
    body        = pos_r - 9'd2;
    done        = 1'b0;
    cand_hit    = 1'b0;
    case (phase_r)
      PH_HDR: begin
        if (offset_r == OFF_CTRL) ctrl_nxt = b;
        if (offset_r >= OFF_A1_FIRST && offset_r <= OFF_A1_LAST)
          station_nxt = {station_r[39:0], b};
        if (offset_r >= OFF_A3_FIRST && offset_r <= OFF_A3_LAST)
          bssid_nxt = {bssid_r[39:0], b};
        if (offset_r == OFF_CATEGORY) cat_nxt = b;
        if (offset_r == OFF_ACTION) begin
          act_nxt = b;
          if (ctrl_r == FC_ACTION && cat_r == CAT_WNM && b == ACT_BTM_REQ) begin
            phase_nxt = PH_FIXED;
            pos_nxt   = '0;
          end else begin
            phase_nxt = PH_OTHER;
          end
        end
      end
      PH_OTHER: begin
      end
      PH_FIXED: begin
        fixed_nxt = {fixed_r[31:0], b};
        if (pos_r >= FIXED_LAST) begin
          pos_nxt = '0;
          if (fixed_nxt[24 + MODE_TERM_BIT]) begin
            phase_nxt = PH_TERM;
            skip_nxt  = TERM_LEN;
          end else begin
            phase_nxt = after_term(fixed_nxt[31:24]);
          end
        end else begin
          pos_nxt = pos_r + 9'd1;
        end
      end
      PH_TERM: begin
        skip_nxt = skip_r - 8'd1;
        if (skip_nxt == 8'd0) phase_nxt = after_term(fixed_r[31:24]);
      end
      PH_URLLEN: begin
        skip_nxt  = b;
        phase_nxt = (b == 8'd0) ? PH_ELEM : PH_URL;
      end
      PH_URL: begin
        skip_nxt = skip_r - 8'd1;
        if (skip_nxt == 8'd0) phase_nxt = PH_ELEM;
      end
      PH_ELEM: begin
        if (pos_r == 9'd0) begin
          tag_nxt = b;
          pos_nxt = 9'd1;
        end else if (pos_r == 9'd1) begin
          len_nxt    = b;
          pos_nxt    = 9'd2;
          cshift_nxt = '0;
          done       = (b == 8'd0);
        end else begin
          if (body < BSSID_BYTES) cshift_nxt = {cshift_r[39:0], b};
          pos_nxt = pos_r + 9'd1;
          done    = (body + 9'd1) >= {1'b0, len_r};
        end
        if (done) begin
          if (tag_nxt == TAG_NEIGHBOR && len_nxt >= MIN_NR_LEN) begin
            if (ctotal_r < CW'(MAX_CANDIDATES)) begin
              cand_hit   = 1'b1;
              ctotal_nxt = ctotal_r + CW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          pos_nxt = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Event for the queue
  always_comb begin
    evt           = '0;
    evt.cand      = cand_hit;
    evt.summ      = in_word.last_byte;
    if (phase_nxt == PH_HDR || ctrl_nxt != FC_ACTION) evt.skind = KIND_NOT_ACTION;
    else if (phase_nxt == PH_OTHER)                   evt.skind = KIND_OTHER;
    else if (phase_nxt == PH_ELEM)                    evt.skind = KIND_BTM;
    else                                              evt.skind = KIND_TRUNC;
    evt.category  = cat_nxt;
    evt.action    = act_nxt;
    evt.fixed     = fixed_nxt;
    evt.station   = station_nxt;
    evt.cand_addr = cshift_nxt;
    evt.bssid     = bssid_nxt;
    evt.cnum      = 4'(ctotal_r);
    evt.dropped   = ovf_nxt;
    evt_push      = accept && (cand_hit || in_word.last_byte);
  end

  // Whole context clears at reset and after every last byte
  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_word.last_byte)) begin
      offset_r  <= '0;
      phase_r   <= PH_HDR;
      ctrl_r    <= '0;
      cat_r     <= '0;
      act_r     <= '0;
      fixed_r   <= '0;
      station_r <= '0;
      bssid_r   <= '0;
      skip_r    <= '0;
      tag_r     <= '0;
      len_r     <= '0;
      pos_r     <= '0;
      cshift_r  <= '0;
      ctotal_r  <= '0;
      ovf_r     <= 1'b0;
    end else if (accept) begin
      offset_r  <= offset_nxt;
      phase_r   <= phase_nxt;
      ctrl_r    <= ctrl_nxt;
      cat_r     <= cat_nxt;
      act_r     <= act_nxt;
      fixed_r   <= fixed_nxt;
      station_r <= station_nxt;
      bssid_r   <= bssid_nxt;
      skip_r    <= skip_nxt;
      tag_r     <= tag_nxt;
      len_r     <= len_nxt;
      pos_r     <= pos_nxt;
      cshift_r  <= cshift_nxt;
      ctotal_r  <= ctotal_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

endmodule

// File: sv/btm_rfp_queue.sv
// ----------------------------------------------------------------------------
// btm_rfp_queue
// Small FIFO of parser events between front and back.
// ----------------------------------------------------------------------------
module btm_rfp_queue #(
  parameter int unsigned DEPTH = btm_rfp_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  btm_rfp_pkg::evt_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output btm_rfp_pkg::evt_t head
);
  import btm_rfp_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  evt_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] count_r,  count_nxt;
  logic          do_push, do_pop;

  assign full       = (count_r == NW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    count_nxt = count_r + NW'(do_push) - NW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

// File: sv/btm_rfp_back.sv
// ----------------------------------------------------------------------------
// btm_rfp_back
// Turns queue events into result words: candidate first, then summary.
// Output register decouples from the receiver.
// ----------------------------------------------------------------------------
module btm_rfp_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   head_valid,
  input  btm_rfp_pkg::evt_t      head,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output btm_rfp_pkg::out_word_t out_word
);
  import btm_rfp_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r,  out_word_nxt;
  logic      half_r,      half_nxt;   // candidate of head entry already sent
  logic      load;
  logic      emit_cand;
  logic      btm;

  assign load      = head_valid && (!out_valid_r || !out_stall);
  assign emit_cand = head.cand && !half_r;
  assign pop       = load && !(emit_cand && head.summ);

  always_comb begin
    out_word_nxt             = '0;
    out_word_nxt.result_kind = emit_cand ? KIND_CAND : head.skind;
    btm = (out_word_nxt.result_kind == KIND_CAND) || (out_word_nxt.result_kind == KIND_BTM);
    if (out_word_nxt.result_kind != KIND_NOT_ACTION) begin
      out_word_nxt.category    = head.category;
      out_word_nxt.action_code = head.action;
    end
    if (btm) begin
      out_word_nxt.token_byte         = head.fixed[39:32];
      out_word_nxt.mode_bits          = head.fixed[31:24];
      out_word_nxt.disassoc_delay     = {head.fixed[15:8], head.fixed[23:16]};
      out_word_nxt.validity_window    = head.fixed[7:0];
      out_word_nxt.target_station     = head.station;
      out_word_nxt.bss_address        = emit_cand ? head.cand_addr : head.bssid;
      out_word_nxt.candidate_number   = emit_cand ? head.cnum
                                                  : head.cnum + 4'(head.cand);
      out_word_nxt.candidates_dropped = head.dropped;
    end
    out_word_nxt.end_of_frame = !emit_cand;

    out_valid_nxt = load ? 1'b1 : (out_valid_r && out_stall);
    half_nxt      = load ? (emit_cand && head.summ) : half_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      half_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      half_r      <= half_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// File: sv/btm_request_frame_parser.sv
// ----------------------------------------------------------------------------
// btm_request_frame_parser
// 802.11 BSS Transition Management request parser, one frame byte per word.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall / in_word): one frame byte per word,
// starting at frame control, last_byte set on the final byte. A word is taken
// on a rising edge with in_valid high and in_stall low.
// Output channel (out_valid / out_stall / out_word): one result per word. Each
// Neighbor Report candidate, up to MAX_CANDIDATES per frame, gives a kind-0 word;
// every frame ends with one summary word (end_of_frame set). A candidate closed
// by the last byte is followed by the summary on the next output word.
// Throughput: one byte per cycle while the queue is not full. The front parser
// decodes the byte in the cycle it is taken; results go to a QUEUE_DEPTH-entry queue.
// A result is written into the queue at the edge that takes its byte, and then
// into the output register (behind any older results).
// Back pressure: while out_stall is high the output word holds; bytes keep
// flowing until the queue fills, then in_stall rises.
// Reset (rst_n low, synchronous) empties queue and output, and returns the
// parser to the start of a frame. No clearing pass is needed.
// ----------------------------------------------------------------------------
module btm_request_frame_parser #(
  parameter int unsigned MAX_CANDIDATES = btm_rfp_pkg::MAX_CANDIDATES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  btm_rfp_pkg::in_word_t  in_word,
  output logic                   out_valid,
  input  logic                   out_stall,
  output btm_rfp_pkg::out_word_t out_word
);
  import btm_rfp_pkg::*;

  logic accept;
  logic evt_push;
  evt_t evt;
  logic q_full;
  logic q_pop;
  logic q_head_valid;
  evt_t q_head;

  // Stall only on a full queue: one event per byte at most.
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  btm_rfp_front #(
    .MAX_CANDIDATES(MAX_CANDIDATES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_word  (in_word),
    .evt_push (evt_push),
    .evt      (evt)
  );

  btm_rfp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (evt_push),
    .push_data  (evt),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  btm_rfp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word)
  );

endmodule

// File: sv/btm_rfp_checker.sv
// ----------------------------------------------------------------------------
// btm_rfp_checker
// Port-level checks on the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "btm_request_frame_parser_assert.svh"

module btm_rfp_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input btm_rfp_pkg::in_word_t  in_word,
  input logic                   out_valid,
  input logic                   out_stall,
  input btm_rfp_pkg::out_word_t out_word
);
  import btm_rfp_pkg::*;

  logic unused_in;
  assign unused_in = in_valid ^ in_stall ^ (^in_word);

  `BTM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word), "output word changed while stalled")
  `BTM_ASSERT_IMPL(a_cand_not_eof, out_valid && out_word.result_kind == KIND_CAND, !out_word.end_of_frame, "candidate marked end of frame")
  `BTM_ASSERT_IMPL(a_not_action_zero, out_valid && out_word.result_kind == KIND_NOT_ACTION, out_word.category == 8'd0 && out_word.action_code == 8'd0 && out_word.end_of_frame, "non-action summary carries action fields")
  `BTM_ASSERT_IMPL(a_plain_summary_zero, out_valid && (out_word.result_kind == KIND_OTHER || out_word.result_kind == KIND_TRUNC), out_word.target_station == 48'd0 && out_word.bss_address == 48'd0 && out_word.candidate_number == 4'd0, "summary without BTM fields carries addresses")

endmodule

bind btm_request_frame_parser btm_rfp_checker u_checker (.*);

// File: tb/btm_request_frame_parser_tb.sv
// ----------------------------------------------------------------------------
// btm_request_frame_parser_tb
// Self-checking bench for the BTM request frame parser.
// ----------------------------------------------------------------------------
// Frames are built byte by byte and queued for a clocked driver. Every byte the
// block takes is run through a parser model kept here, which queues the result
// words the byte should cause. A clocked monitor compares each result word it
// takes, field by field, with the oldest queued one. Both sides idle in random
// bursts, the receiver holds off once for a long stretch, and the run ends
// with a stretch that has no idling at all.
// ----------------------------------------------------------------------------
module btm_request_frame_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import btm_rfp_pkg::*;

  localparam int CAND_LIMIT  = MAX_CANDIDATES_DEF;
  localparam int HOLD_CYCLES = 200;   // long receiver hold-off
  localparam int IDLE_LIMIT  = 1000;  // cycles with no word taken on either side
  localparam int DRAIN_WAIT  = 20;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  btm_request_frame_parser #(.MAX_CANDIDATES(CAND_LIMIT)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Bytes waiting to be sent and result words the parser model still owes.
  in_word_t   pending_bytes[$];
  out_word_t  results_due[$];
  logic [7:0] frame_buf[$];   // frame under construction
  int         queued_bytes = 0;
  int         errors = 0;

  // Run control shared by the stimulus, driver and monitor.
  bit quiet = 1'b0;           // no idling on either side
  bit long_hold_req = 1'b0;   // receiver to hold off for HOLD_CYCLES

  // --------------------------------------------------------------------------
  // Parser model state
  // --------------------------------------------------------------------------
  logic [4:0]  hdr_pos;       // header offset, saturates past the action code
  phase_t      stage;
  logic [7:0]  fc_byte;
  logic [7:0]  cat_byte;
  logic [7:0]  act_byte;
  logic [39:0] btm_fixed;     // token, mode, timer lo, timer hi, validity
  logic [47:0] sta_addr;
  logic [47:0] bss_addr;
  logic [7:0]  skip_left;
  logic [7:0]  elem_tag;
  logic [7:0]  elem_len;
  int          elem_pos;      // byte within fixed fields or element
  logic [47:0] cand_shift;
  int          cand_count;
  logic        cand_over;

  task automatic clear_parse();
    hdr_pos    = '0;
    stage      = PH_HDR;
    fc_byte    = '0;
    cat_byte   = '0;
    act_byte   = '0;
    btm_fixed  = '0;
    sta_addr   = '0;
    bss_addr   = '0;
    skip_left  = '0;
    elem_tag   = '0;
    elem_len   = '0;
    elem_pos   = 0;
    cand_shift = '0;
    cand_count = 0;
    cand_over  = 1'b0;
  endtask

  function automatic out_word_t make_result(input logic [2:0] kind, input bit btm,
                                            input logic [47:0] addr,
                                            input logic [3:0] num, input bit eof);
    out_word_t r;
    r = '0;
    r.result_kind = kind;
    if (kind != KIND_NOT_ACTION) begin
      r.category    = cat_byte;
      r.action_code = act_byte;
    end
    if (btm) begin
      r.token_byte         = btm_fixed[39:32];
      r.mode_bits          = btm_fixed[31:24];
      r.disassoc_delay     = {btm_fixed[15:8], btm_fixed[23:16]};  // little endian
      r.validity_window    = btm_fixed[7:0];
      r.target_station     = sta_addr;
      r.bss_address        = addr;
      r.candidate_number   = num;
      r.candidates_dropped = cand_over;
    end
    r.end_of_frame = eof;
    return r;
  endfunction

  // Mode bit 4 decides whether a URL follows the termination field.
  function automatic phase_t url_or_elements();
    return btm_fixed[24 + MODE_URL_BIT] ? PH_URLLEN : PH_ELEM;
  endfunction

  // Advance the model by one taken byte, queueing the words it should cause.
  task automatic parse_byte(input in_word_t w);
    logic [7:0] b;
    bit         done;
    int         body;
    b    = w.frame_byte;
    done = 1'b0;
    case (stage)
      PH_HDR: begin
        if (hdr_pos == OFF_CTRL) fc_byte = b;
        if (hdr_pos >= OFF_A1_FIRST && hdr_pos <= OFF_A1_LAST) sta_addr = {sta_addr[39:0], b};
        if (hdr_pos >= OFF_A3_FIRST && hdr_pos <= OFF_A3_LAST) bss_addr = {bss_addr[39:0], b};
        if (hdr_pos == OFF_CATEGORY) cat_byte = b;
        if (hdr_pos == OFF_ACTION) begin
          act_byte = b;
          if (fc_byte == FC_ACTION && cat_byte == CAT_WNM && act_byte == ACT_BTM_REQ) begin
            stage    = PH_FIXED;
            elem_pos = 0;
          end else begin
            stage = PH_OTHER;
          end
        end
      end
      PH_OTHER: ;
      PH_FIXED: begin
        btm_fixed = {btm_fixed[31:0], b};
        elem_pos++;
        if (elem_pos > FIXED_LAST) begin
          elem_pos = 0;
          if (btm_fixed[24 + MODE_TERM_BIT]) begin
            stage     = PH_TERM;
            skip_left = TERM_LEN;
          end else begin
            stage = url_or_elements();
          end
        end
      end
      PH_TERM: begin
        skip_left--;
        if (skip_left == 0) stage = url_or_elements();
      end
      PH_URLLEN: begin
        skip_left = b;
        stage     = (b == 0) ? PH_ELEM : PH_URL;
      end
      PH_URL: begin
        skip_left--;
        if (skip_left == 0) stage = PH_ELEM;
      end
      default: begin
        // tag, length, body; the first six body bytes are the BSSID
        if (elem_pos == 0) begin
          elem_tag = b;
          elem_pos = 1;
        end else if (elem_pos == 1) begin
          elem_len   = b;
          elem_pos   = 2;
          cand_shift = '0;
          done       = (b == 0);
        end else begin
          body = elem_pos - 2;
          if (body < BSSID_BYTES) cand_shift = {cand_shift[39:0], b};
          elem_pos++;
          done = (body + 1 >= int'(elem_len));
        end
        if (done) begin
          if (elem_tag == TAG_NEIGHBOR && elem_len >= MIN_NR_LEN) begin
            if (cand_count < CAND_LIMIT) begin
              results_due.push_back(make_result(KIND_CAND, 1'b1, cand_shift,
                                                cand_count[3:0], 1'b0));
              cand_count++;
            end else begin
              cand_over = 1'b1;
            end
          end
          elem_pos = 0;
        end
      end
    endcase

    if (hdr_pos < OFF_SAT) hdr_pos++;

    // Summary word closes every frame, after any candidate closed by this byte.
    if (w.last_byte) begin
      if (stage == PH_HDR || fc_byte != FC_ACTION)
        results_due.push_back(make_result(KIND_NOT_ACTION, 1'b0, '0, '0, 1'b1));
      else if (stage == PH_OTHER)
        results_due.push_back(make_result(KIND_OTHER, 1'b0, '0, '0, 1'b1));
      else if (stage == PH_ELEM)
        results_due.push_back(make_result(KIND_BTM, 1'b1, bss_addr, cand_count[3:0], 1'b1));
      else
        results_due.push_back(make_result(KIND_TRUNC, 1'b0, '0, '0, 1'b1));
      clear_parse();
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  task automatic field_check(input string name, input logic [47:0] want,
                             input logic [47:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_result(input out_word_t want, input out_word_t got);
    field_check("result_kind", 48'(want.result_kind), 48'(got.result_kind));
    field_check("category", 48'(want.category), 48'(got.category));
    field_check("action_code", 48'(want.action_code), 48'(got.action_code));
    field_check("token_byte", 48'(want.token_byte), 48'(got.token_byte));
    field_check("mode_bits", 48'(want.mode_bits), 48'(got.mode_bits));
    field_check("disassoc_delay", 48'(want.disassoc_delay), 48'(got.disassoc_delay));
    field_check("validity_window", 48'(want.validity_window), 48'(got.validity_window));
    field_check("target_station", want.target_station, got.target_station);
    field_check("bss_address", want.bss_address, got.bss_address);
    field_check("candidate_number", 48'(want.candidate_number),
                48'(got.candidate_number));
    field_check("candidates_dropped", 48'(want.candidates_dropped),
                48'(got.candidates_dropped));
    field_check("end_of_frame", 48'(want.end_of_frame), 48'(got.end_of_frame));
  endtask

  // --------------------------------------------------------------------------
  // Frame construction
  // --------------------------------------------------------------------------
  task automatic put_filler(input int n);
    repeat (n) frame_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  // Starts a new frame: frame control, random header body, category, action.
  task automatic put_header(input logic [7:0] fc, input logic [7:0] cat,
                            input logic [7:0] act);
    frame_buf.delete();
    frame_buf.push_back(fc);
    put_filler(OFF_CATEGORY - 1);
    frame_buf.push_back(cat);
    frame_buf.push_back(act);
  endtask

  // Overwrites addr1 through addr3 with one byte value.
  task automatic fill_addresses(input logic [7:0] v);
    for (int i = OFF_A1_FIRST; i <= OFF_A3_LAST; i++) frame_buf[i] = v;
  endtask

  // Fixed fields, then the termination field and URL that the mode asks for.
  task automatic put_fixed(input logic [7:0] token, input logic [7:0] mode,
                           input logic [15:0] timer, input logic [7:0] validity,
                           input int url_len);
    frame_buf.push_back(token);
    frame_buf.push_back(mode);
    frame_buf.push_back(timer[7:0]);
    frame_buf.push_back(timer[15:8]);
    frame_buf.push_back(validity);
    if (mode[MODE_TERM_BIT]) put_filler(int'(TERM_LEN));
    if (mode[MODE_URL_BIT]) begin
      frame_buf.push_back(url_len[7:0]);
      put_filler(url_len);
    end
  endtask

  task automatic put_element(input logic [7:0] tag, input int len);
    frame_buf.push_back(tag);
    frame_buf.push_back(len[7:0]);
    put_filler(len);
  endtask

  // Queues the first keep bytes of the frame (all of it if keep is 0).
  task automatic ship_frame(input int keep);
    in_word_t w;
    int       n;
    n = (keep <= 0 || keep > frame_buf.size()) ? frame_buf.size() : keep;
    for (int i = 0; i < n; i++) begin
      w.frame_byte = frame_buf[i];
      w.last_byte  = (i == n - 1);
      pending_bytes.push_back(w);
    end
    queued_bytes += n;
  endtask

  task automatic random_element();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0)
      put_element(TAG_NEIGHBOR, $urandom_range(MIN_NR_LEN, 255));
    else if (sel < 11)
      put_element(TAG_NEIGHBOR, $urandom_range(MIN_NR_LEN, MIN_NR_LEN + 5));
    else if (sel < 14)
      put_element(TAG_NEIGHBOR, $urandom_range(0, MIN_NR_LEN - 1));
    else
      put_element(8'($urandom_range(0, 255)), $urandom_range(0, 16));
  endtask

  // Mostly well-formed requests with random content; the rest is other
  // actions and noise, short frames among it.
  task automatic random_frame();
    int         sel;
    int         n_el;
    logic [7:0] fc;
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      put_header(FC_ACTION, CAT_WNM, ACT_BTM_REQ);
      put_fixed(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12));
      n_el = ($urandom_range(0, 5) == 0) ? $urandom_range(CAND_LIMIT, CAND_LIMIT + 4)
                                         : $urandom_range(0, 5);
      repeat (n_el) random_element();
      ship_frame(($urandom_range(0, 5) == 0) ? $urandom_range(1, frame_buf.size()) : 0);
    end else if (sel < 80) begin
      put_header(FC_ACTION, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      put_filler($urandom_range(0, 8));
      ship_frame(0);
    end else begin
      fc = $urandom_range(0, 1) ? FC_ACTION : 8'($urandom_range(0, 255));
      if ($urandom_range(0, 1))
        put_header(fc, CAT_WNM, ACT_BTM_REQ);
      else
        put_header(fc, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      put_filler($urandom_range(0, 20));
      ship_frame($urandom_range(1, frame_buf.size()));
    end
  endtask

  // Sender pause: nothing more goes out until every owed word has come.
  task automatic drain();
    while (pending_bytes.size() != 0 || in_valid || results_due.size() != 0)
      @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers queued bytes, holds a stalled word, idles in bursts.
  // --------------------------------------------------------------------------
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) parse_byte(in_word);
      if (in_valid && in_stall) begin
        // stalled word stays put
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_bytes.size() == 0) begin
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        gap_left = $urandom_range(0, 17);
        in_valid <= 1'b0;
      end else begin
        in_word  <= pending_bytes.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: takes result words, checks them, stalls in bursts and once for a
  // long stretch so the block backs up into its input.
  // --------------------------------------------------------------------------
  int stall_left = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          $display("%0t: result word with none owed, expected none, actual %0h",
                   $time, out_word);
          errors++;
        end else begin
          check_result(results_due.pop_front(), out_word);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(0, 17);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: too long with no word taken on either channel ends the run.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    clear_parse();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Short frames: a single byte, then one byte shy of the action code.
    put_header(FC_ACTION, CAT_WNM, ACT_BTM_REQ);
    ship_frame(1);
    put_header(FC_ACTION, CAT_WNM, ACT_BTM_REQ);
    ship_frame(int'(OFF_ACTION));
    // Wrong frame control ahead of an otherwise good request.
    put_header(8'h00, CAT_WNM, ACT_BTM_REQ);
    put_fixed(8'h11, 8'h00, 16'h1234, 8'h05, 0);
    put_element(TAG_NEIGHBOR, int'(MIN_NR_LEN));
    ship_frame(0);
    // Request that ends right on the action code: truncated.
    put_header(FC_ACTION, CAT_WNM, ACT_BTM_REQ);
    ship_frame(0);
    // Other actions.
    put_header(FC_ACTION, 8'hFF, 8'hFF);
    put_filler(4);
    ship_frame(0);
    put_header(FC_ACTION, CAT_WNM, 8'h06);
    ship_frame(0);
    put_header(FC_ACTION, 8'h00, ACT_BTM_REQ);
    ship_frame(0);
    // All-zero request with no elements.
    put_header(FC_ACTION, CAT_WNM, ACT_BTM_REQ);
    fill_addresses(8'h00);
    put_fixed(8'h00, 8'h00, 16'h0000, 8'h00, 0);
    ship_frame(0);
    // All-ones request: termination and URL, report closing on the last byte.
    put_header(FC_ACTION, CAT_WNM, ACT_BTM_REQ);
    fill_addresses(8'hFF);
    put_fixed(8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 3);
    put_element(TAG_NEIGHBOR, int'(MIN_NR_LEN));
    ship_frame(0);
    // Cut inside the fixed fields, the termination field, on the URL length,
    // and deep inside a maximum-length URL.
    put_header(FC_ACTION, CAT_WNM, ACT_BTM_REQ);
    put_fixed(8'h01, 8'h00, 16'h0100, 8'h0A, 0);
    ship_frame(OFF_SAT + 2);
    put_header(FC_ACTION, CAT_WNM, ACT_BTM_REQ);
    put_fixed(8'h02, 8'h08, 16'h0200, 8'h0B, 0);
    ship_frame(OFF_SAT + 9);
    put_header(FC_ACTION, CAT_WNM, ACT_BTM_REQ);
    put_fixed(8'h03, 8'h10, 16'h0000, 8'h01, 5);
    ship_frame(OFF_SAT + 6);
    put_header(FC_ACTION, CAT_WNM, ACT_BTM_REQ);
    put_fixed(8'h04, 8'h18, 16'h00FF, 8'h7F, 255);
    ship_frame(OFF_SAT + 118);
    // Empty URL, then two reports.
    put_header(FC_ACTION, CAT_WNM, ACT_BTM_REQ);
    put_fixed(8'h05, 8'h10, 16'hABCD, 8'h10, 0);
    put_element(TAG_NEIGHBOR, int'(MIN_NR_LEN));
    put_element(TAG_NEIGHBOR, 20);
    ship_frame(0);
    // More reports than candidate slots.
    put_header(FC_ACTION, CAT_WNM, ACT_BTM_REQ);
    put_fixed(8'h06, 8'h01, 16'h0001, 8'hFE, 0);
    repeat (CAND_LIMIT + 2) put_element(TAG_NEIGHBOR, int'(MIN_NR_LEN));
    ship_frame(0);
    // Short report, empty elements, a longest report, then a report cut short.
    put_header(FC_ACTION, CAT_WNM, ACT_BTM_REQ);
    put_fixed(8'h07, 8'h00, 16'h8000, 8'h80, 0);
    put_element(TAG_NEIGHBOR, MIN_NR_LEN - 1);
    put_element(TAG_NEIGHBOR, 0);
    put_element(8'hDD, 0);
    put_element(TAG_NEIGHBOR, 255);
    put_element(TAG_NEIGHBOR, int'(MIN_NR_LEN));
    ship_frame(frame_buf.size() - 5);
    drain();

    // Random frames; the receiver holds off long enough to fill the block.
    queued_bytes  = 0;
    long_hold_req = 1'b1;
    while (queued_bytes < 200) random_frame();
    drain();

    while (queued_bytes < 320) random_frame();
    drain();

    // Last part at full rate on both sides.
    quiet = 1'b1;
    while (queued_bytes < 440) random_frame();
    drain();

    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0 && results_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
